// ===== rtl/core/cle_pkg.sv =====
package cle_pkg;

    localparam int DEFAULT_BUF_DEPTH = 128;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CTRL_D = 8'h04;
    localparam logic [7:0] CH_CTRL_H = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_CTRL_P = 8'h10;
    localparam logic [7:0] CH_CTRL_U = 8'h15;
    localparam logic [7:0] CH_CTRL_X = 8'h18;
    localparam logic [7:0] CH_CTRL_Y = 8'h19;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic [6:0] ERASE_MAX = 7'd127;

    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ECHO_NONE  = 2'd0;
    localparam logic [1:0] ECHO_CHAR  = 2'd1;
    localparam logic [1:0] ECHO_ERASE = 2'd2;

    localparam logic [1:0] RD_NONE  = 2'd0;
    localparam logic [1:0] RD_DATA  = 2'd1;
    localparam logic [1:0] RD_EMPTY = 2'd2;
    localparam logic [1:0] RD_EOF   = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_char;
        logic       read_partial;
    } req_t;

    typedef struct packed {
        logic [1:0] echo_kind;
        logic [7:0] echo_char;
        logic [6:0] erase_count;
        logic       line_committed;
        logic [1:0] read_status;
        logic [7:0] read_byte;
        logic       read_line_end;
    } rsp_t;

endpackage

// ===== rtl/core/console_line_editor_core.sv =====
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | cle_pkg::req_t (operation, rx_char, read_partial)
// rsp     | out       | rsp_valid/rsp_stall | cle_pkg::rsp_t (echo and read result)
//
// A receive transaction does its store write and pointer update at the
// accepting edge, and its result is registered at that same edge.
// A read transaction loads the synchronous store read at the accepting edge;
// in ST_LOOKUP, once the output is free, the byte is decoded and read_ptr may move.
// Reset clears the three pointers and control state; the store is not cleared.
// A stalled result holds req off until it is taken or leaves in that cycle.
module console_line_editor_core #(
    parameter int BUF_DEPTH = cle_pkg::DEFAULT_BUF_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  cle_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cle_pkg::rsp_t rsp
);

    localparam int WRAP   = 2 * BUF_DEPTH;
    localparam int PTR_W  = $clog2(WRAP);
    localparam int SLOT_W = $clog2(BUF_DEPTH);
    localparam int EXT_W  = (PTR_W > 7) ? PTR_W : 7;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(WRAP - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        ptr_dec = (p == '0) ? PTR_W'(WRAP - 1) : p - PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        if (a >= b)
        begin
            s = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            s = {1'b0, a} + (PTR_W+1)'(WRAP) - {1'b0, b};
        end
        ptr_dist = s[PTR_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot(input logic [PTR_W-1:0] p);
        slot = (p >= PTR_W'(BUF_DEPTH)) ? SLOT_W'(p - PTR_W'(BUF_DEPTH)) : SLOT_W'(p);
    endfunction

    cle_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0] read_ptr_reg, read_ptr_next;
    logic [PTR_W-1:0] commit_ptr_reg, commit_ptr_next;
    logic [PTR_W-1:0] edit_ptr_reg, edit_ptr_next;
    logic             partial_reg, partial_next;
    logic             rsp_valid_reg, rsp_valid_next;
    cle_pkg::rsp_t    rsp_reg, rsp_next;

    logic [7:0] line_store [BUF_DEPTH];
    logic [7:0] rd_data_reg;

    logic              out_free;
    logic              accept;
    logic              rx_accept;
    logic              mem_re;
    logic              load_read;
    logic              mem_we;
    logic [7:0]        mem_wdata;
    logic [PTR_W-1:0]  dist_ec;
    logic [PTR_W-1:0]  dist_er;
    logic [EXT_W-1:0]  dist_ext;
    logic [7:0]        ch;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign rx_accept = accept && (req.operation == cle_pkg::OP_RX);

    assign dist_ec  = ptr_dist(edit_ptr_reg, commit_ptr_reg);
    assign dist_er  = ptr_dist(edit_ptr_reg, read_ptr_reg);
    assign dist_ext = EXT_W'(dist_ec);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cle_pkg::ST_IDLE:
            begin
                if (accept && req.operation == cle_pkg::OP_READ)
                begin
                    state_next = cle_pkg::ST_LOOKUP;
                end
            end
            cle_pkg::ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = cle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cle_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        req_stall = 1'b1;
        mem_re    = 1'b0;
        load_read = 1'b0;
        case (state_reg)
            cle_pkg::ST_IDLE:
            begin
                req_stall = !out_free;
                mem_re    = req_valid && out_free && (req.operation == cle_pkg::OP_READ);
            end
            cle_pkg::ST_LOOKUP:
            begin
                load_read = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // edit and read datapath
    always_comb
    begin
        read_ptr_next   = read_ptr_reg;
        commit_ptr_next = commit_ptr_reg;
        edit_ptr_next   = edit_ptr_reg;
        partial_next    = partial_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        mem_we          = 1'b0;
        mem_wdata       = '0;
        ch              = req.rx_char;

        if (accept)
        begin
            partial_next = req.read_partial;
        end

        if (rx_accept)
        begin
            rsp_next       = '0;
            rsp_valid_next = 1'b1;
            if (ch == cle_pkg::CH_CTRL_U)
            begin
                if (edit_ptr_reg != commit_ptr_reg)
                begin
                    edit_ptr_next        = commit_ptr_reg;
                    rsp_next.echo_kind   = cle_pkg::ECHO_ERASE;
                    rsp_next.erase_count = (dist_ext > EXT_W'(cle_pkg::ERASE_MAX)) ?
                                           cle_pkg::ERASE_MAX : dist_ext[6:0];
                end
            end
            else if (ch == cle_pkg::CH_CTRL_H || ch == cle_pkg::CH_DEL)
            begin
                if (edit_ptr_reg != commit_ptr_reg)
                begin
                    edit_ptr_next        = ptr_dec(edit_ptr_reg);
                    rsp_next.echo_kind   = cle_pkg::ECHO_ERASE;
                    rsp_next.erase_count = 7'd1;
                end
            end
            else if (ch == cle_pkg::CH_CTRL_P || ch == cle_pkg::CH_CTRL_X ||
                     ch == cle_pkg::CH_CTRL_Y || ch == cle_pkg::CH_NUL)
            begin
                rsp_next.echo_kind = cle_pkg::ECHO_NONE;
            end
            else if (dist_er < PTR_W'(BUF_DEPTH))
            begin
                if (ch == cle_pkg::CH_CR)
                begin
                    ch = cle_pkg::CH_LF;
                end
                rsp_next.echo_kind = cle_pkg::ECHO_CHAR;
                rsp_next.echo_char = ch;
                mem_we             = 1'b1;
                mem_wdata          = ch;
                edit_ptr_next      = ptr_inc(edit_ptr_reg);
                if (ch == cle_pkg::CH_LF || ch == cle_pkg::CH_CTRL_D ||
                    dist_er == PTR_W'(BUF_DEPTH - 1))
                begin
                    commit_ptr_next         = ptr_inc(edit_ptr_reg);
                    rsp_next.line_committed = 1'b1;
                end
            end
        end

        if (load_read)
        begin
            rsp_next       = '0;
            rsp_valid_next = 1'b1;
            if (read_ptr_reg == commit_ptr_reg)
            begin
                rsp_next.read_status = cle_pkg::RD_EMPTY;
            end
            else if (rd_data_reg == cle_pkg::CH_CTRL_D)
            begin
                rsp_next.read_status = cle_pkg::RD_EOF;
                if (!partial_reg)
                begin
                    read_ptr_next = ptr_inc(read_ptr_reg);
                end
            end
            else
            begin
                read_ptr_next          = ptr_inc(read_ptr_reg);
                rsp_next.read_status   = cle_pkg::RD_DATA;
                rsp_next.read_byte     = rd_data_reg;
                rsp_next.read_line_end = (rd_data_reg == cle_pkg::CH_LF);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cle_pkg::ST_IDLE;
            read_ptr_reg   <= '0;
            commit_ptr_reg <= '0;
            edit_ptr_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            read_ptr_reg   <= read_ptr_next;
            commit_ptr_reg <= commit_ptr_next;
            edit_ptr_reg   <= edit_ptr_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        partial_reg <= partial_next;
        rsp_reg     <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_store[slot(edit_ptr_reg)] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= line_store[slot(read_ptr_reg)];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_dist(edit_ptr_reg, read_ptr_reg) <= PTR_W'(BUF_DEPTH))
        else $error("edit pointer ran past buffer depth");

    a_commit_order: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_dist(commit_ptr_reg, read_ptr_reg) <= ptr_dist(edit_ptr_reg, read_ptr_reg))
        else $error("commit pointer outside read..edit window");

    a_rx_result: assert property (@(posedge clk) disable iff (!rst_n)
        rx_accept |=> rsp_valid_reg && state_reg == cle_pkg::ST_IDLE)
        else $error("receive transaction produced no result");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.operation == cle_pkg::OP_READ |=> state_reg == cle_pkg::ST_LOOKUP)
        else $error("read transaction did not enter lookup");

    a_lookup_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cle_pkg::ST_LOOKUP && out_free |=>
        rsp_valid_reg && rsp_reg.read_status != cle_pkg::RD_NONE)
        else $error("lookup left without a read result");

endmodule
